// ===== rtl/fmqd_pkg.sv =====
// Shared constants, types and helpers of the FM cross-product discriminator.
package fmqd_pkg;

	localparam int RAW_W         = 8;
	localparam int CTR_W         = 9;
	localparam int ACC_W         = 18;
	localparam int MAG_W         = 15;
	localparam int DEN_W         = 16;
	localparam int OUT_W         = 32;
	localparam int MUL_STEPS     = 9;
	localparam int MUL_CNT_W     = 4;
	localparam int FRAC_BITS_DEF = 15;
	localparam logic [CTR_W-1:0] ZERO_LEVEL = 9'd127;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic start;
	} eng_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eng_stat_t;

	function automatic logic signed [CTR_W-1:0] center(input logic [RAW_W-1:0] raw);
		center = signed'({1'b0, raw} - ZERO_LEVEL);
	endfunction

endpackage

// ===== rtl/fmqd_if.sv =====
// Valid/ready channel interfaces for I/Q input items and audio result items.
interface fmqd_in_if
	import fmqd_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] i_sample;
	logic [RAW_W-1:0] q_sample;
	logic             last_of_block;

	modport source (output valid, i_sample, q_sample, last_of_block, input ready);
	modport sink (input valid, i_sample, q_sample, last_of_block, output ready);
endinterface

interface fmqd_out_if
	import fmqd_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] audio_sample;
	logic                    audio_last;

	modport source (output valid, audio_sample, audio_last, input ready);
	modport sink (input valid, audio_sample, audio_last, output ready);
endinterface

// ===== rtl/fm_quadrature_discriminator_core.sv =====
// A result-bearing item runs 9 shift-add steps and then 15+FRAC_BITS divider steps, and
// its quotient is then loaded into the output register as the audio item. The input takes
// no new item until that load; an item that only seeds the held pair is taken without
// starting the engines. An audio item that is not taken stalls the load.
// The output register frees the input side.
// Reset (arst_n low) clears the state, held pair, have-previous flag and output valid flag.
module fm_quadrature_discriminator_core
	import fmqd_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	fmqd_in_if.sink           iq,
	fmqd_out_if.source        audio
);

	localparam int DVD_W = MAG_W + FRAC_BITS;

	seq_state_t              state_q, state_d;
	logic [RAW_W-1:0]        prev_i_q, prev_q_q;
	logic                    have_prev_q, last_q, neg_q;
	logic                    accept, load_out;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] out_sample_q;
	logic                    out_last_q;
	eng_ctl_t                mac_ctl, div_ctl;
	eng_stat_t               mac_stat, div_stat;
	logic signed [ACC_W-1:0] num;
	logic [DEN_W-1:0]        den, den_clamped;
	logic signed [ACC_W-1:0] num_abs;
	logic [DVD_W-1:0]        quo;
	logic [OUT_W-1:0]        quo_ext;

	assign accept = iq.valid && iq.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept && have_prev_q) state_d = ST_MUL;
			ST_MUL:  if (mac_stat.done) state_d = ST_DIV;
			ST_DIV:  if (div_stat.done) state_d = ST_DONE;
			ST_DONE: if (!out_valid_q || audio.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		iq.ready      = state_q == ST_IDLE;
		mac_ctl.start = state_q == ST_IDLE && accept && have_prev_q;
		div_ctl.start = state_q == ST_MUL && mac_stat.done;
		load_out      = state_q == ST_DONE && (!out_valid_q || audio.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_i_q    <= '0;
			prev_q_q    <= '0;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				prev_i_q    <= iq.i_sample;
				prev_q_q    <= iq.q_sample;
				have_prev_q <= !iq.last_of_block;
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (audio.ready)
				out_valid_q <= 1'b0;
		end
	end

	fmqd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.prev_i (center(prev_i_q)),
		.prev_q (center(prev_q_q)),
		.cur_i  (center(iq.i_sample)),
		.cur_q  (center(iq.q_sample)),
		.num    (num),
		.den    (den),
		.stat   (mac_stat)
	);

	assign num_abs     = num[ACC_W-1] ? -num : num;
	assign den_clamped = (den == '0) ? DEN_W'(1) : den;

	fmqd_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.mag    (num_abs[MAG_W-1:0]),
		.den    (den_clamped),
		.quo    (quo),
		.stat   (div_stat)
	);

	assign quo_ext = {{(OUT_W-DVD_W){1'b0}}, quo};

	always_ff @(posedge clk) begin
		if (mac_ctl.start)
			last_q <= iq.last_of_block;
		if (div_ctl.start)
			neg_q <= num[ACC_W-1];
		if (load_out) begin
			out_sample_q <= neg_q ? -signed'(quo_ext) : signed'(quo_ext);
			out_last_q   <= last_q;
		end
	end

	assign audio.valid        = out_valid_q;
	assign audio.audio_sample = out_sample_q;
	assign audio.audio_last   = out_last_q;

`ifndef ASSERT_OFF
	a_start_mul: assert property (@(posedge clk) disable iff (!arst_n)
		accept && have_prev_q |=> state_q == ST_MUL)
		else $error("result-bearing item did not start the multiply");
	a_mac_done: assert property (@(posedge clk) disable iff (!arst_n)
		mac_stat.done |-> state_q == ST_MUL)
		else $error("multiply finished outside its phase");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divide finished outside its phase");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> !out_valid_q || audio.ready)
		else $error("output item overwritten before it was taken");
`endif

endmodule

// ===== rtl/fmqd_mac.sv =====
// Bit-serial shift-add unit for the cross-product numerator and magnitude denominator.
module fmqd_mac
	import fmqd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  eng_ctl_t                ctl,
	input  logic signed [CTR_W-1:0] prev_i,
	input  logic signed [CTR_W-1:0] prev_q,
	input  logic signed [CTR_W-1:0] cur_i,
	input  logic signed [CTR_W-1:0] cur_q,
	output logic signed [ACC_W-1:0] num,
	output logic [DEN_W-1:0]        den,
	output eng_stat_t               stat
);

	logic [CTR_W-1:0]        bits_i_q, bits_q_q;
	logic signed [ACC_W-1:0] m_pi_q, m_pq_q, m_ci_q, m_cq_q;
	logic signed [ACC_W-1:0] num_q, den_q;
	logic signed [ACC_W-1:0] term_num, term_den;
	logic [MUL_CNT_W-1:0]    cnt_q;
	logic                    busy_q, done_q, last_step;

	assign last_step = cnt_q == MUL_CNT_W'(MUL_STEPS - 1);

	always_comb begin
		term_num = (bits_q_q[0] ? m_pi_q : '0) - (bits_i_q[0] ? m_pq_q : '0);
		term_den = (bits_i_q[0] ? m_ci_q : '0) + (bits_q_q[0] ? m_cq_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// sign bit of the multiplier carries negative weight
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			bits_i_q <= cur_i;
			bits_q_q <= cur_q;
			m_pi_q   <= ACC_W'(prev_i);
			m_pq_q   <= ACC_W'(prev_q);
			m_ci_q   <= ACC_W'(cur_i);
			m_cq_q   <= ACC_W'(cur_q);
			num_q    <= '0;
			den_q    <= '0;
		end else if (busy_q) begin
			bits_i_q <= bits_i_q >> 1;
			bits_q_q <= bits_q_q >> 1;
			m_pi_q   <= m_pi_q <<< 1;
			m_pq_q   <= m_pq_q <<< 1;
			m_ci_q   <= m_ci_q <<< 1;
			m_cq_q   <= m_cq_q <<< 1;
			if (last_step) begin
				num_q <= num_q - term_num;
				den_q <= den_q - term_den;
			end else begin
				num_q <= num_q + term_num;
				den_q <= den_q + term_den;
			end
		end
	end

	assign num       = num_q;
	assign den       = den_q[DEN_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/fmqd_div.sv =====
// Restoring divider, one quotient bit per cycle, for the scaled numerator magnitude.
module fmqd_div
	import fmqd_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  eng_ctl_t                          ctl,
	input  logic [MAG_W-1:0]                  mag,
	input  logic [DEN_W-1:0]                  den,
	output logic [MAG_W+FRAC_BITS-1:0]        quo,
	output eng_stat_t                         stat
);

	localparam int DVD_W = MAG_W + FRAC_BITS;
	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] dvd_q;
	logic [DEN_W-1:0] rem_q, den_q, trial;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q, fits;

	assign trial = {rem_q[DEN_W-2:0], dvd_q[DVD_W-1]};
	assign fits  = trial >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= {mag, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= fits ? trial - den_q : trial;
		end
	end

	assign quo       = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== test/fmqd_audio_checker.sv =====
// Checker that predicts the discriminator's audio items and compares them with the block's output.
module fmqd_audio_checker
	import fmqd_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	fmqd_in_if   iq,
	fmqd_out_if  audio,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic signed [OUT_W-1:0] sample;
		logic                    last;
	} audio_item_t;

	audio_item_t      expected_audio_q[$];
	logic [RAW_W-1:0] held_i;
	logic [RAW_W-1:0] held_q;
	logic             held_valid;

	function automatic logic signed [OUT_W-1:0] predict_audio(
		input logic [RAW_W-1:0] prev_i_raw,
		input logic [RAW_W-1:0] prev_q_raw,
		input logic [RAW_W-1:0] cur_i_raw,
		input logic [RAW_W-1:0] cur_q_raw
	);
		longint pi;
		longint pq;
		longint ci;
		longint cq;
		longint num;
		longint den;
		longint quo;
		pi  = longint'(prev_i_raw) - 127;
		pq  = longint'(prev_q_raw) - 127;
		ci  = longint'(cur_i_raw) - 127;
		cq  = longint'(cur_q_raw) - 127;
		num = pi * cq - pq * ci;
		den = ci * ci + cq * cq;
		if (den < 1) begin
			den = 1;
		end
		quo = (num * (longint'(1) << FRAC_BITS)) / den;
		if (quo > longint'(32'sh7fffffff)) begin
			quo = longint'(32'sh7fffffff);
		end
		if (quo < -longint'(32'sh7fffffff) - 1) begin
			quo = -longint'(32'sh7fffffff) - 1;
		end
		return quo[OUT_W-1:0];
	endfunction

	initial begin
		fail_count = 0;
		pending    = 0;
		held_i     = '0;
		held_q     = '0;
		held_valid = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		audio_item_t got;
		audio_item_t want;
		if (!arst_n) begin
			held_i     = '0;
			held_q     = '0;
			held_valid = 1'b0;
		end else begin
			if (audio.valid && audio.ready) begin
				got.sample = audio.audio_sample;
				got.last   = audio.audio_last;
				if (expected_audio_q.size() == 0) begin
					$error("unexpected audio item: audio_sample %0d, audio_last %0b",
						got.sample, got.last);
					fail_count++;
				end else begin
					want = expected_audio_q.pop_front();
					if (got.sample !== want.sample) begin
						$error("audio_sample: expected %0d, actual %0d", want.sample, got.sample);
						fail_count++;
					end
					if (got.last !== want.last) begin
						$error("audio_last: expected %0b, actual %0b", want.last, got.last);
						fail_count++;
					end
				end
			end
			if (iq.valid && iq.ready) begin
				if (held_valid) begin
					want.sample = predict_audio(held_i, held_q, iq.i_sample, iq.q_sample);
					want.last   = iq.last_of_block;
					expected_audio_q.push_back(want);
				end
				held_i     = iq.i_sample;
				held_q     = iq.q_sample;
				held_valid = !iq.last_of_block;
			end
			pending = expected_audio_q.size();
		end
	end

endmodule

// ===== test/tb_fm_quadrature_discriminator_core.sv =====
// Testbench top: drives I/Q items and audio backpressure, and reports the verdict.
module tb_fm_quadrature_discriminator_core;
	import fmqd_pkg::*;

	localparam int FRAC         = FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int LONG_HOLD    = 500;
	localparam int RANDOM_ITEMS = 1050;
	localparam int END_WAIT     = 100;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   cycle_count = 0;
	bit   calm        = 1'b0;
	bit   rush        = 1'b0;
	bit   hold_req    = 1'b0;

	fmqd_in_if  iq_ch();
	fmqd_out_if audio_ch();

	fm_quadrature_discriminator_core #(
		.FRAC_BITS(FRAC)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.iq    (iq_ch),
		.audio (audio_ch)
	);

	fmqd_audio_checker #(
		.FRAC_BITS(FRAC)
	) checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.iq        (iq_ch),
		.audio     (audio_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [RAW_W-1:0] pick_byte();
		if ($urandom_range(0, 3) == 0) begin
			return RAW_W'(125 + $urandom_range(0, 4));
		end
		return RAW_W'($urandom);
	endfunction

	task automatic send_iq(input logic [RAW_W-1:0] i_val, input logic [RAW_W-1:0] q_val,
			input logic last_val);
		if (!calm && !rush && $urandom_range(0, 5) == 0) begin
			iq_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		iq_ch.valid         <= 1'b1;
		iq_ch.i_sample      <= i_val;
		iq_ch.q_sample      <= q_val;
		iq_ch.last_of_block <= last_val;
		@(posedge clk);
		while (!iq_ch.ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		iq_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		int len;
		audio_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				audio_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				len = $urandom_range(1, 19);
				audio_ch.ready <= 1'b0;
				repeat (len) @(posedge clk);
			end else begin
				audio_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int sent;
		int blk_len;
		bit mark;
		bit hold_done;
		bit paused;
		sent      = 0;
		hold_done = 1'b0;
		paused    = 1'b0;
		iq_ch.valid         <= 1'b0;
		iq_ch.i_sample      <= '0;
		iq_ch.q_sample      <= '0;
		iq_ch.last_of_block <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_iq(8'd0, 8'd0, 1'b0);
		send_iq(8'd255, 8'd255, 1'b0);
		send_iq(8'd127, 8'd127, 1'b0);
		send_iq(8'd0, 8'd255, 1'b0);
		send_iq(8'd255, 8'd0, 1'b0);
		send_iq(8'd0, 8'd0, 1'b0);
		send_iq(8'd255, 8'd255, 1'b0);
		send_iq(8'd127, 8'd128, 1'b0);
		send_iq(8'd255, 8'd255, 1'b0);
		send_iq(8'd128, 8'd127, 1'b1);
		send_iq(8'd10, 8'd200, 1'b1);
		send_iq(8'd50, 8'd60, 1'b0);
		send_iq(8'd127, 8'd127, 1'b0);
		send_iq(8'd127, 8'd127, 1'b1);
		send_iq(8'd255, 8'd0, 1'b0);
		send_iq(8'd0, 8'd255, 1'b0);
		send_iq(8'd126, 8'd127, 1'b0);
		send_iq(8'd127, 8'd126, 1'b0);
		send_iq(8'd170, 8'd85, 1'b0);
		send_iq(8'd85, 8'd170, 1'b1);

		while (sent < RANDOM_ITEMS) begin
			if (sent >= 300 && !hold_done) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
				rush      = 1'b1;
			end
			if (sent >= 360) begin
				rush = 1'b0;
			end
			if (sent >= 500 && !paused) begin
				wait_drained();
				paused = 1'b1;
			end
			if (sent >= 900) begin
				calm = 1'b1;
			end
			blk_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
			for (int k = 0; k < blk_len; k++) begin
				mark = (k == blk_len - 1) || ($urandom_range(0, 63) == 0);
				send_iq(pick_byte(), pick_byte(), mark);
				sent++;
			end
		end

		wait_drained();
		repeat (END_WAIT) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/fmqd_pkg.sv
rtl/fmqd_if.sv
rtl/fmqd_mac.sv
rtl/fmqd_div.sv
rtl/fm_quadrature_discriminator_core.sv
test/fmqd_audio_checker.sv
test/tb_fm_quadrature_discriminator_core.sv
